// ===== sv/trapezoid_motion_profile_assert.svh =====
// Assertion macros for the trapezoid motion profile checker.
`ifndef TRAPEZOID_MOTION_PROFILE_ASSERT_SVH
`define TRAPEZOID_MOTION_PROFILE_ASSERT_SVH

// next-cycle implication, masked during reset
`define TMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tmp check failed");

// next-cycle implication, also checked across reset
`define TMP_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tmp check failed");

`endif

// ===== sv/tmp_pkg.sv =====
// Package: types, constants and register codes of the trapezoid motion profile.
package tmp_pkg;

    typedef logic [7:0] t_cfg_idx;

    localparam t_cfg_idx REG_ACCEL = 8'd0;
    localparam t_cfg_idx REG_SPEED = 8'd1;
    localparam t_cfg_idx REG_DIST  = 8'd2;
    localparam t_cfg_idx REG_TICK  = 8'd3;

    localparam logic [31:0] ACCEL_RST = 32'd65536;
    localparam logic [31:0] SPEED_RST = 32'd65536;
    localparam logic [31:0] DIST_RST  = 32'd0;
    localparam logic [23:0] TICK_RST  = 24'd167772;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_WW,
        ST_CMP,
        ST_DIV,
        ST_SQRT,
        ST_FIN,
        ST_TICKS
    } t_solve_state;

    typedef enum logic [2:0] {
        J_TRI,
        J_TM,
        J_PS,
        J_LIN,
        J_TICKS
    } t_div_job;

    typedef enum logic [1:0] {
        RG_ACCEL,
        RG_CRUISE,
        RG_DECEL,
        RG_HOLD
    } t_region;

    typedef struct packed {
        logic        trap;
        logic [31:0] accel;
        logic [31:0] speed;
        logic [31:0] move_dist;
        logic [47:0] tm;
        logic [48:0] te;
        logic [49:0] tt;
        logic [63:0] ps;
        logic [15:0] ticks;
    } t_profile;

endpackage

// ===== sv/tmp_in_if.sv =====
// Input channel: one sample time per item.
interface tmp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_time;

    modport source (output valid, output sample_time, input ready);
    modport sink   (input valid, input sample_time, output ready);
endinterface

// ===== sv/tmp_out_if.sv =====
// Output channel: position, profile kind and tick count per item.
interface tmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic               profile_kind;
    logic        [15:0] total_ticks;

    modport source (output valid, output position, output profile_kind, output total_ticks,
                    input ready);
    modport sink   (input valid, input position, input profile_kind, input total_ticks,
                    output ready);
endinterface

// ===== sv/tmp_cfg_if.sv =====
// Configuration write channel: register index and data.
interface tmp_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/trapezoid_motion_profile.sv =====
// Trapezoid motion profile: one sample time in, one position out per cycle while the
// solver is idle and the output is not stalled, six register stages from input to output.
// Phase times, cruise offset and tick count are solved once after reset and after every
// configuration write by a shared bit-serial divider and square root unit; input ready
// stays low meanwhile. Registers: 0 accel_max, 1 speed_max, 2 move_distance,
// 3 tick_period.
module trapezoid_motion_profile (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmp_in_if.sink    i_in,
    tmp_cfg_if.sink   i_cfg,
    tmp_out_if.source o_out
);
    import tmp_pkg::*;

    logic [31:0] r_accel;
    logic [31:0] r_speed;
    logic [31:0] r_dist;
    logic [23:0] r_tick;
    logic        cfg_wr;
    logic        busy;
    t_profile    prof;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= ACCEL_RST;
            r_speed <= SPEED_RST;
            r_dist  <= DIST_RST;
            r_tick  <= TICK_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                REG_ACCEL: r_accel <= i_cfg.data;
                REG_SPEED: r_speed <= i_cfg.data;
                REG_DIST:  r_dist  <= i_cfg.data;
                REG_TICK:  r_tick  <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    tmp_solver u_solver (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_wr),
        .i_accel (r_accel),
        .i_speed (r_speed),
        .i_dist  (r_dist),
        .i_tick  (r_tick),
        .o_busy  (busy),
        .o_prof  (prof)
    );

    // pipeline valid bits and stall chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

    assign rdy_o = !r_ov || o_out.ready;
    assign rdy5  = !r_v5 || rdy_o;
    assign rdy4  = !r_v4 || rdy5;
    assign rdy3  = !r_v3 || rdy4;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign i_in.ready = rdy1 && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1)  r_v1 <= i_in.valid && i_in.ready;
            if (rdy2)  r_v2 <= r_v1;
            if (rdy3)  r_v3 <= r_v2;
            if (rdy4)  r_v4 <= r_v3;
            if (rdy5)  r_v5 <= r_v4;
            if (rdy_o) r_ov <= r_v5;
        end
    end

    // stage 1: time sample
    logic [31:0] r_s1_t;

    // stage 2: phase and multiplier operands
    t_region     r_s2_rg;
    logic [31:0] r_s2_u;
    logic [31:0] r_s2_dt;
    t_region     s1_rg;
    logic [49:0] s1_t;
    logic [49:0] s1_u;

    assign s1_t = {18'd0, r_s1_t};
    assign s1_u = prof.tt - s1_t;

    always_comb begin
        priority if (s1_t <= {2'b0, prof.tm}) begin
            s1_rg = RG_ACCEL;
        end else if (s1_t <= {1'b0, prof.te}) begin
            s1_rg = RG_CRUISE;
        end else if (s1_t < prof.tt) begin
            s1_rg = RG_DECEL;
        end else begin
            s1_rg = RG_HOLD;
        end
    end

    // stage 3: a*u and cruise product
    t_region     r_s3_rg;
    logic [31:0] r_s3_u;
    logic [63:0] r_s3_au;
    logic [63:0] r_s3_cp;

    // stage 4: a*u*u partial products and cruise sum
    t_region     r_s4_rg;
    logic [63:0] r_s4_lo;
    logic [63:0] r_s4_hi;
    logic [63:0] r_s4_cs;

    // stage 5: rounded square term
    t_region     r_s5_rg;
    logic [62:0] r_s5_v;
    logic [47:0] r_s5_c;
    logic [95:0] s4_p;

    assign s4_p = {r_s4_hi, 32'd0} + {32'd0, r_s4_lo} + 96'h1_0000_0000;

    // output stage: position select and saturation
    logic signed [31:0] r_o_pos;
    logic               r_o_kind;
    logic        [15:0] r_o_ticks;
    logic        [31:0] s5_pos;
    logic        [32:0] s5_vv;
    logic signed [34:0] s5_diff;

    assign s5_vv   = (r_s5_v > 63'h1_8000_0000) ? 33'h1_8000_0000 : r_s5_v[32:0];
    assign s5_diff = $signed({3'b0, prof.move_dist}) - $signed({2'b0, s5_vv});

    always_comb begin
        unique case (r_s5_rg)
            RG_ACCEL:  s5_pos = (r_s5_v > 63'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_s5_v[31:0];
            RG_CRUISE: s5_pos = (r_s5_c > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_s5_c[31:0];
            RG_DECEL: begin
                priority if (s5_diff > 35'sh0_7FFF_FFFF) begin
                    s5_pos = 32'h7FFF_FFFF;
                end else if (s5_diff < -35'sh0_8000_0000) begin
                    s5_pos = 32'h8000_0000;
                end else begin
                    s5_pos = s5_diff[31:0];
                end
            end
            RG_HOLD:   s5_pos = prof.move_dist[31] ? 32'h7FFF_FFFF : prof.move_dist;
            default:   s5_pos = prof.move_dist;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_t <= i_in.sample_time;
        end
        if (rdy2) begin
            r_s2_rg <= s1_rg;
            r_s2_u  <= (s1_rg == RG_DECEL) ? s1_u[31:0] : r_s1_t;
            r_s2_dt <= r_s1_t - prof.tm[31:0];
        end
        if (rdy3) begin
            r_s3_rg <= r_s2_rg;
            r_s3_u  <= r_s2_u;
            r_s3_au <= {32'd0, prof.accel} * {32'd0, r_s2_u};
            r_s3_cp <= {32'd0, r_s2_dt} * {32'd0, prof.speed};
        end
        if (rdy4) begin
            r_s4_rg <= r_s3_rg;
            r_s4_lo <= {32'd0, r_s3_au[31:0]} * {32'd0, r_s3_u};
            r_s4_hi <= {32'd0, r_s3_au[63:32]} * {32'd0, r_s3_u};
            r_s4_cs <= {prof.ps[48:0], 15'd0} + r_s3_cp + 64'h8000;
        end
        if (rdy5) begin
            r_s5_rg <= r_s4_rg;
            r_s5_v  <= s4_p[95:33];
            r_s5_c  <= r_s4_cs[63:16];
        end
        if (rdy_o) begin
            r_o_pos   <= $signed(s5_pos);
            r_o_kind  <= prof.trap;
            r_o_ticks <= prof.ticks;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.position     = r_o_pos;
    assign o_out.profile_kind = r_o_kind;
    assign o_out.total_ticks  = r_o_ticks;

endmodule

// ===== sv/tmp_solver.sv =====
// Profile solver: derives phase times, cruise offset and tick count from the registers.
module tmp_solver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_accel,
    input  logic [31:0]        i_speed,
    input  logic [31:0]        i_dist,
    input  logic [23:0]        i_tick,
    output logic               o_busy,
    output tmp_pkg::t_profile  o_prof
);
    import tmp_pkg::*;

    t_solve_state r_state, n_state;
    t_div_job     r_job, n_job;
    t_profile     r_prof, n_prof;
    logic [23:0]  r_tick, n_tick;
    logic [63:0]  r_da, n_da;
    logic [63:0]  r_ww, n_ww;
    logic [47:0]  r_lin, n_lin;
    logic [63:0]  r_dvd, n_dvd;
    logic [31:0]  r_dsr, n_dsr;
    logic [32:0]  r_rem, n_rem;
    logic [5:0]   r_cnt, n_cnt;
    logic [63:0]  r_sx, n_sx;
    logic [63:0]  r_sr, n_sr;

    logic [32:0]  rem_sh;
    logic         div_ge;
    logic [63:0]  quo;
    logic [63:0]  sq_bit;
    logic [63:0]  sq_sum;
    logic [63:0]  sq_r;
    logic [5:0]   sq_shift;
    logic [31:0]  d_rest;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_prof  = r_prof;
        n_tick  = r_tick;
        n_da    = r_da;
        n_ww    = r_ww;
        n_lin   = r_lin;
        n_dvd   = r_dvd;
        n_dsr   = r_dsr;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_sx    = r_sx;
        n_sr    = r_sr;

        rem_sh   = {r_rem[31:0], r_dvd[63]};
        div_ge   = rem_sh >= {1'b0, r_dsr};
        quo      = {r_dvd[62:0], div_ge};
        sq_shift = 6'd62 - {r_cnt[4:0], 1'b0};
        sq_bit   = 64'd1 << sq_shift;
        sq_sum   = r_sr + sq_bit;
        sq_r     = (r_sx >= sq_sum) ? ({1'b0, r_sr[63:1]} + sq_bit) : {1'b0, r_sr[63:1]};
        d_rest   = r_prof.move_dist - quo[31:0];

        unique case (r_state)
            ST_IDLE: begin
            end
            ST_START: begin
                n_prof.accel     = (i_accel == 32'd0) ? 32'd1 : i_accel;
                n_prof.speed     = (i_speed == 32'd0) ? 32'd1 : i_speed;
                n_prof.move_dist = i_dist;
                n_tick           = (i_tick == 24'd0) ? 24'd1 : i_tick;
                n_prof.ps        = '0;
                n_lin            = '0;
                n_da             = {32'd0, i_dist} * {32'd0, ((i_accel == 32'd0) ? 32'd1 : i_accel)};
                n_state          = ST_MUL_WW;
            end
            ST_MUL_WW: begin
                n_ww    = {32'd0, r_prof.speed} * {32'd0, r_prof.speed};
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_prof.trap = !(r_da < r_ww);
                n_rem       = '0;
                n_cnt       = '0;
                n_dsr       = r_prof.accel;
                n_state     = ST_DIV;
                if (r_da < r_ww) begin
                    n_job = J_TRI;
                    n_dvd = {r_prof.move_dist, 32'd0};
                end else begin
                    n_job = J_TM;
                    n_dvd = {16'd0, r_prof.speed, 16'd0};
                end
            end
            ST_DIV: begin
                n_rem = div_ge ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
                n_dvd = quo;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_rem = '0;
                    n_cnt = '0;
                    unique case (r_job)
                        J_TRI: begin
                            n_sx    = quo;
                            n_sr    = '0;
                            n_state = ST_SQRT;
                        end
                        J_TM: begin
                            n_prof.tm = quo[47:0];
                            n_job     = J_PS;
                            n_dvd     = r_ww;
                            n_dsr     = r_prof.accel;
                        end
                        J_PS: begin
                            n_prof.ps = quo;
                            n_job     = J_LIN;
                            n_dvd     = {16'd0, d_rest, 16'd0};
                            n_dsr     = r_prof.speed;
                        end
                        J_LIN: begin
                            n_lin   = quo[47:0];
                            n_state = ST_FIN;
                        end
                        J_TICKS: begin
                            n_prof.ticks = (|quo[63:16]) ? 16'hFFFF : quo[15:0];
                            n_state      = ST_IDLE;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SQRT: begin
                if (r_sx >= sq_sum) begin
                    n_sx = r_sx - sq_sum;
                end
                n_sr  = sq_r;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_prof.tm = sq_r[47:0];
                    n_cnt     = '0;
                    n_state   = ST_FIN;
                end
            end
            ST_FIN: begin
                n_prof.te = {1'b0, r_prof.tm} + {1'b0, r_lin};
                n_prof.tt = {1'b0, r_prof.tm, 1'b0} + {2'b0, r_lin};
                n_state   = ST_TICKS;
            end
            ST_TICKS: begin
                n_dvd   = {5'd0, r_prof.tt, 9'd0} + {40'd0, r_tick};
                n_dsr   = {7'd0, r_tick, 1'b0};
                n_rem   = '0;
                n_cnt   = '0;
                n_job   = J_TICKS;
                n_state = ST_DIV;
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_start) begin
            n_state = ST_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_job   <= J_TRI;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prof <= n_prof;
        r_tick <= n_tick;
        r_da   <= n_da;
        r_ww   <= n_ww;
        r_lin  <= n_lin;
        r_dvd  <= n_dvd;
        r_dsr  <= n_dsr;
        r_rem  <= n_rem;
        r_sx   <= n_sx;
        r_sr   <= n_sr;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_prof = r_prof;

endmodule

// ===== sv/tmp_checker.sv =====
// Port checker for the trapezoid motion profile, bound to the top level.
`include "trapezoid_motion_profile_assert.svh"

module tmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_cfg_valid,
    input logic        i_cfg_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_position
);
    `TMP_ASSERT_NEXT_NR(a_rst_blocks_in, i_clk, !i_rst_n, !i_in_ready)
    `TMP_ASSERT_NEXT(a_cfg_blocks_in, i_clk, i_rst_n, i_cfg_valid && i_cfg_ready, !i_in_ready)
    `TMP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `TMP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_position))
endmodule

bind trapezoid_motion_profile tmp_checker u_tmp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_cfg_valid    (i_cfg.valid),
    .i_cfg_ready    (i_cfg.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_position (o_out.position)
);

// ===== test/tb_trapezoid_motion_profile.sv =====
// Testbench for trapezoid_motion_profile: directed and random sample times checked per item.
`timescale 1ns / 1ps

module tb_trapezoid_motion_profile;
    import tmp_pkg::*;

    localparam t_cfg_idx REG_UNUSED = 8'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 68;

    typedef struct packed {
        logic signed [31:0] position;
        logic               profile_kind;
        logic        [15:0] total_ticks;
    } t_sample_result;

    typedef enum logic [1:0] {AT_ABS, AT_TM, AT_TE, AT_TT} t_anchor;
    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        t_anchor        anchor;
        int             off;
        t_cfg_idx       idx;
        logic [31:0]    data;
        logic           typed;
        t_sample_result exp;
    } t_row;

    localparam int NROWS = 33;
    localparam t_sample_result ZERO_RES = '0;

    t_row dir_rows [0:NROWS-1] = '{
        '{ROW_SAMPLE, AT_ABS, 0,          REG_ACCEL, 32'h0,        1'b1, ZERO_RES},
        '{ROW_SAMPLE, AT_ABS, 1,          REG_ACCEL, 32'h0,        1'b1, ZERO_RES},
        '{ROW_SAMPLE, AT_ABS, 32'h7fffffff, REG_ACCEL, 32'h0,      1'b1, ZERO_RES},
        '{ROW_SAMPLE, AT_ABS, -1,         REG_ACCEL, 32'h0,        1'b1, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_ACCEL, 32'h10000,    1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_SPEED, 32'h10000,    1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_DIST,  32'h40000,    1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TM,  0,          REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TM,  1,          REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TE,  0,          REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TE,  1,          REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TT,  -1,         REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TT,  0,          REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_ABS, 32'h7fff,   REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_DIST,  32'h8000,     1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TM,  0,          REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TT,  -1,         REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        // zero registers behave as one
        '{ROW_CFG,    AT_ABS, 0,          REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_SPEED, 32'h0,        1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_TICK,  32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_ABS, 32'h12345678, REG_ACCEL, 32'h0,      1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_ACCEL, 32'hffffffff, 1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_SPEED, 32'hffffffff, 1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_DIST,  32'hffffffff, 1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_TICK,  32'hffffff,   1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TM,  0,          REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TT,  -1,         REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        // unknown index is ignored; slow accel over a huge distance saturates
        '{ROW_CFG,    AT_ABS, 0,          REG_UNUSED, 32'h1,       1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_ACCEL, 32'h1,        1'b0, ZERO_RES},
        '{ROW_CFG,    AT_ABS, 0,          REG_TICK,  32'h1,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_ABS, 32'h80000000, REG_ACCEL, 32'h0,      1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_TT,  -1,         REG_ACCEL, 32'h0,        1'b0, ZERO_RES},
        '{ROW_SAMPLE, AT_ABS, -1,         REG_ACCEL, 32'h0,        1'b0, ZERO_RES}
    };

    logic i_clk;
    logic i_rst_n;

    tmp_in_if  in_ch();
    tmp_cfg_if cfg_ch();
    tmp_out_if out_ch();

    trapezoid_motion_profile dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    logic [31:0] accel_q, speed_q, dist_q;
    logic [23:0] tick_q;
    t_sample_result pending_samples [$];
    int errors;
    int idle_cycles;
    bit quiet;
    bit hold_req;
    int hold_left;
    int burst_left;

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // round(a*u*u / 2^33) with the 64-bit wrap of a*u, saturated
    function automatic logic [63:0] half_square(logic [63:0] a, logic [63:0] u);
        logic [63:0]  au;
        logic [127:0] p;
        au = a * u;
        p = {64'd0, au} * {64'd0, u} + 128'h1_0000_0000;
        if (p[127:97] != 0) return '1;
        return p[96:33];
    endfunction

    function automatic void solve_phases(output logic trap, output logic [63:0] tm,
                                         output logic [63:0] te, output logic [63:0] tt,
                                         output logic [63:0] ps);
        logic [63:0] a, w, d, lin;
        a = (accel_q != 0) ? {32'd0, accel_q} : 64'd1;
        w = (speed_q != 0) ? {32'd0, speed_q} : 64'd1;
        d = {32'd0, dist_q};
        trap = !(d * a < w * w);
        ps = 0;
        if (!trap) begin
            tm = isqrt64((d << 32) / a);
            te = tm;
            tt = 2 * tm;
        end else begin
            tm = (w << 16) / a;
            ps = (w * w) / a;
            lin = ((d - ps) << 16) / w;
            te = tm + lin;
            tt = 2 * tm + lin;
        end
    endfunction

    function automatic t_sample_result predict_sample(logic [31:0] t_in);
        logic trap;
        logic [63:0] tm, te, tt, ps, a, w, d, t, tp, v, n, q;
        longint pos;
        t_sample_result r;
        solve_phases(trap, tm, te, tt, ps);
        a = (accel_q != 0) ? {32'd0, accel_q} : 64'd1;
        w = (speed_q != 0) ? {32'd0, speed_q} : 64'd1;
        tp = (tick_q != 0) ? {40'd0, tick_q} : 64'd1;
        d = {32'd0, dist_q};
        t = {32'd0, t_in};
        if (t <= tm) begin
            v = half_square(a, t);
            pos = (v > 64'h7fffffff) ? 64'h7fffffff : v;
        end else if (t <= te) begin
            v = (ps << 15) + (t - tm) * w + 64'h8000;
            pos = v >> 16;
        end else if (t < tt) begin
            v = half_square(a, tt - t);
            if (v > 64'h1_8000_0000) v = 64'h1_8000_0000;
            pos = longint'(d) - longint'(v);
        end else begin
            pos = d;
        end
        if (pos > 64'sd2147483647) pos = 64'sd2147483647;
        if (pos < -64'sd2147483648) pos = -64'sd2147483648;
        n = tt << 8;
        q = (2 * n + tp) / (2 * tp);
        r.position = pos[31:0];
        r.profile_kind = trap;
        r.total_ticks = (q > 65535) ? 16'hffff : q[15:0];
        return r;
    endfunction

    function automatic logic [31:0] anchored_time(t_anchor anc, int off);
        logic trap;
        logic [63:0] tm, te, tt, ps;
        longint base;
        solve_phases(trap, tm, te, tt, ps);
        case (anc)
            AT_TM: base = longint'(tm) + longint'(off);
            AT_TE: base = longint'(te) + longint'(off);
            AT_TT: base = longint'(tt) + longint'(off);
            default: base = {32'd0, off};
        endcase
        if (base < 0) base = 0;
        if (base > 64'hffffffff) base = 64'hffffffff;
        return base[31:0];
    endfunction

    function automatic logic [31:0] random_time();
        logic trap;
        logic [63:0] tm, te, tt, ps, span;
        int sel;
        solve_phases(trap, tm, te, tt, ps);
        sel = $urandom_range(0, 9);
        span = tt + (tt >> 3) + 1;
        if (span > 64'hffffffff) span = 64'hffffffff;
        if (sel < 4) begin
            case ($urandom_range(0, 2))
                0: return anchored_time(AT_TM, $signed($urandom_range(0, 128)) - 64);
                1: return anchored_time(AT_TE, $signed($urandom_range(0, 128)) - 64);
                default: return anchored_time(AT_TT, $signed($urandom_range(0, 128)) - 64);
            endcase
        end
        if (sel < 8) return $urandom_range(0, span[31:0]);
        return $urandom;
    endfunction

    function automatic logic [31:0] random_reg(t_cfg_idx idx);
        logic [31:0] v;
        bit wild;
        wild = ($urandom_range(0, 4) < 2);
        if (idx == REG_TICK) begin
            if (!wild) return $urandom_range(1000, 2000000);
            case ($urandom_range(0, 3))
                0: v = 0;
                1: v = 32'hffffff;
                2: v = 1;
                default: v = $urandom;
            endcase
            return v & 32'hffffff;
        end
        if (!wild) return $urandom_range(32'h100, 32'h40_0000);
        case ($urandom_range(0, 3))
            0: v = 0;
            1: v = '1;
            2: v = $urandom;
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    task automatic send_sample(logic [31:0] t);
        in_ch.valid <= 1'b1;
        in_ch.sample_time <= t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_samples.push_back(predict_sample(t));
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (12) @(posedge i_clk);
    endtask

    // leaves valid high; the caller lowers it after the last write of a group
    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_ACCEL: accel_q = data;
            REG_SPEED: speed_q = data;
            REG_DIST:  dist_q = data;
            REG_TICK:  tick_q = data[23:0];
            default: ;
        endcase
    endtask

    // receiver: random stall bursts plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst_left <= $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sample_result exp;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected item: position %0d", out_ch.position);
                errors++;
            end else begin
                exp = pending_samples.pop_front();
                if (out_ch.position !== exp.position) begin
                    $error("position: expected %0d, got %0d", exp.position, out_ch.position);
                    errors++;
                end
                if (out_ch.profile_kind !== exp.profile_kind) begin
                    $error("profile_kind: expected %0d, got %0d", exp.profile_kind,
                           out_ch.profile_kind);
                    errors++;
                end
                if (out_ch.total_ticks !== exp.total_ticks) begin
                    $error("total_ticks: expected %0d, got %0d", exp.total_ticks,
                           out_ch.total_ticks);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit cfg_open;
        t_row row;
        logic [31:0] t;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample_time = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        burst_left = 0;
        cfg_open = 1'b0;
        accel_q = ACCEL_RST;
        speed_q = SPEED_RST;
        dist_q = DIST_RST;
        tick_q = TICK_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NROWS; i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                if (!cfg_open) drain_results();
                cfg_open = 1'b1;
                write_reg(row.idx, row.data);
            end else begin
                if (cfg_open) cfg_ch.valid <= 1'b0;
                cfg_open = 1'b0;
                t = anchored_time(row.anchor, row.off);
                in_ch.valid <= 1'b1;
                in_ch.sample_time <= t;
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
                pending_samples.push_back(row.typed ? row.exp : predict_sample(t));
                sender_gap();
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            quiet = (ph >= RANDOM_PHASES - 2);
            write_reg(REG_ACCEL, random_reg(REG_ACCEL));
            write_reg(REG_SPEED, random_reg(REG_SPEED));
            write_reg(REG_DIST, random_reg(REG_DIST));
            write_reg(REG_TICK, random_reg(REG_TICK));
            cfg_ch.valid <= 1'b0;
            if (ph == 2) hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 3 && k == PHASE_ITEMS / 2) drain_results();
                send_sample(random_time());
                sender_gap();
            end
        end
        in_ch.valid <= 1'b0;

        wait (pending_samples.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
